// ===== rtl/mde_pkg.sv =====
// Package: shared types, opcode and function codes for the MIPS decode/execute block.
`default_nettype none

package mde_pkg;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;
	localparam logic [5:0] OP_LL    = 6'h30;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	localparam logic [4:0] LINK_REG = 5'd31;

	localparam logic [1:0] CLASS_R = 2'd0;
	localparam logic [1:0] CLASS_I = 2'd1;
	localparam logic [1:0] CLASS_J = 2'd2;

	typedef enum logic [3:0] {
		ALU_NONE,
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_NOR,
		ALU_SLT,
		ALU_SLTU,
		ALU_SLL,
		ALU_SRL,
		ALU_LINK
	} mde_alu_op_t;

	typedef enum logic [1:0] {
		SRC_RT,
		SRC_SIMM,
		SRC_ZIMM
	} mde_src_t;

	typedef enum logic [2:0] {
		BR_NONE,
		BR_EQ,
		BR_NE,
		BR_JUMP,
		BR_REG
	} mde_br_t;

	typedef struct packed {
		mde_alu_op_t alu_op;
		mde_src_t    src_b;
		mde_br_t     br;
		logic [4:0]  dest_reg;
		logic        reg_write;
		logic        write_from_memory;
		logic        mem_read;
		logic        mem_write;
		logic        store_en;
		logic [1:0]  instr_class;
	} mde_ctrl_t;

	typedef struct packed {
		logic [31:0]        instr;
		logic [31:0]        pc;
		logic signed [31:0] rs_value;
		logic signed [31:0] rt_value;
	} mde_in_t;

	typedef struct packed {
		logic signed [31:0] alu_result;
		logic [4:0]         dest_reg;
		logic               reg_write;
		logic               write_from_memory;
		logic               mem_read;
		logic               mem_write;
		logic signed [31:0] store_data;
		logic               redirect;
		logic [31:0]        next_pc;
		logic [1:0]         instr_class;
		logic [31:0]        link_value;
	} mde_out_t;

endpackage

`default_nettype wire

// ===== rtl/mde_decode.sv =====
// Instruction decoder: opcode and function field to control bundle.
`default_nettype none

module mde_decode (
	input  wire logic [31:0]       instr,
	output mde_pkg::mde_ctrl_t     ctrl
);
	import mde_pkg::*;

	logic [5:0] op;
	logic [5:0] fn;

	assign op = instr[31:26];
	assign fn = instr[5:0];

	always_comb begin
		ctrl                   = '0;
		ctrl.alu_op            = ALU_NONE;
		ctrl.src_b             = SRC_RT;
		ctrl.br                = BR_NONE;
		unique case (op) inside
			OP_RTYPE: begin
				ctrl.instr_class = CLASS_R;
				ctrl.dest_reg    = instr[15:11];
				ctrl.reg_write   = 1'b1;
				unique case (fn) inside
					FN_ADD, FN_ADDU: ctrl.alu_op = ALU_ADD;
					FN_SUB, FN_SUBU: ctrl.alu_op = ALU_SUB;
					FN_AND:          ctrl.alu_op = ALU_AND;
					FN_OR:           ctrl.alu_op = ALU_OR;
					FN_NOR:          ctrl.alu_op = ALU_NOR;
					FN_SLT:          ctrl.alu_op = ALU_SLT;
					FN_SLTU:         ctrl.alu_op = ALU_SLTU;
					FN_SLL:          ctrl.alu_op = ALU_SLL;
					FN_SRL:          ctrl.alu_op = ALU_SRL;
					FN_JR: begin
						ctrl.reg_write = 1'b0;
						ctrl.br        = BR_REG;
					end
					default:         ctrl.reg_write = 1'b0;
				endcase
			end
			OP_J, OP_JAL: begin
				ctrl.instr_class = CLASS_J;
				ctrl.br          = BR_JUMP;
				if (op == OP_JAL) begin
					ctrl.dest_reg  = LINK_REG;
					ctrl.reg_write = 1'b1;
					ctrl.alu_op    = ALU_LINK;
				end
			end
			default: begin
				ctrl.instr_class = CLASS_I;
				ctrl.dest_reg    = instr[20:16];
				ctrl.reg_write   = 1'b1;
				unique case (op) inside
					OP_ADDI, OP_ADDIU, OP_LL: begin
						ctrl.alu_op = ALU_ADD;
						ctrl.src_b  = SRC_SIMM;
					end
					OP_ANDI: begin
						ctrl.alu_op = ALU_AND;
						ctrl.src_b  = SRC_ZIMM;
					end
					OP_ORI: begin
						ctrl.alu_op = ALU_OR;
						ctrl.src_b  = SRC_ZIMM;
					end
					OP_SLTI: begin
						ctrl.alu_op = ALU_SLT;
						ctrl.src_b  = SRC_SIMM;
					end
					OP_LW: begin
						ctrl.alu_op            = ALU_ADD;
						ctrl.src_b             = SRC_SIMM;
						ctrl.write_from_memory = 1'b1;
						ctrl.mem_read          = 1'b1;
					end
					OP_SW: begin
						ctrl.alu_op    = ALU_ADD;
						ctrl.src_b     = SRC_SIMM;
						ctrl.reg_write = 1'b0;
						ctrl.mem_write = 1'b1;
						ctrl.store_en  = 1'b1;
					end
					OP_BEQ: begin
						ctrl.reg_write = 1'b0;
						ctrl.br        = BR_EQ;
					end
					OP_BNE: begin
						ctrl.reg_write = 1'b0;
						ctrl.br        = BR_NE;
					end
					default: ctrl.reg_write = 1'b0;
				endcase
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/mde_alu.sv =====
// Integer ALU: add, subtract, logic, compares and shifts.
`default_nettype none

module mde_alu (
	input  wire mde_pkg::mde_alu_op_t op,
	input  wire logic [31:0]       a,
	input  wire logic [31:0]       b,
	input  wire logic [4:0]        shamt,
	output logic [31:0]            result
);
	import mde_pkg::*;

	always_comb begin
		case (op)
			ALU_ADD:  result = a + b;
			ALU_SUB:  result = a - b;
			ALU_AND:  result = a & b;
			ALU_OR:   result = a | b;
			ALU_NOR:  result = ~(a | b);
			ALU_SLT:  result = {31'd0, ($signed(a) < $signed(b))};
			ALU_SLTU: result = {31'd0, (a < b)};
			ALU_SLL:  result = b << shamt;
			ALU_SRL:  result = b >> shamt;
			default:  result = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/mips_decode_execute_top.sv =====
// Top level: three-stage MIPS32 instruction decode and execute pipeline.
//
// Usage:
//   Drive cmd (instruction word, its pc, rs and rt values) and raise start.
//   A beat is taken at each rising edge with start high and busy low; busy
//   is always low, so one instruction may enter every cycle.
//   Stage 1 registers the operands with the decoded controls, stage 2 runs
//   the ALU, the branch compare and the target adds, stage 3 resolves the
//   redirect and holds the result.
//   The result appears on res with done high once stages 1, 2 and 3 have
//   registered it, for exactly one cycle. Throughput: one beat per cycle.
//   The receiver cannot stall; every result must be taken in the cycle that
//   done is high.
//   Reset (arst_n low) clears all valid bits at once; beats in flight are
//   dropped and done stays low until new beats arrive.
`default_nettype none

module mips_decode_execute_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire mde_pkg::mde_in_t cmd,
	output logic                  done,
	output mde_pkg::mde_out_t     res
);
	import mde_pkg::*;

	mde_ctrl_t   dec_ctrl;

	logic        valid_s1;
	mde_ctrl_t   ctrl_s1;
	logic [31:0] rs_s1;
	logic [31:0] rt_s1;
	logic [25:0] idx_s1;
	logic [31:0] pc_s1;

	logic [31:0] opb;
	logic [31:0] simm;
	logic [31:0] alu_out;
	logic [31:0] pc4;
	logic [31:0] link;

	logic        valid_s2;
	mde_ctrl_t   ctrl_s2;
	logic [31:0] alu_s2;
	logic        eq_s2;
	logic [31:0] pc4_s2;
	logic [31:0] link_s2;
	logic [31:0] btgt_s2;
	logic [31:0] jtgt_s2;
	logic [31:0] rs_s2;
	logic [31:0] sd_s2;

	logic        redir;
	logic [31:0] npc;

	logic        valid_s3;
	mde_out_t    res_s3;

	assign busy = 1'b0;

	mde_decode u_decode (
		.instr (cmd.instr),
		.ctrl  (dec_ctrl)
	);

	// stage 1: register operands with decoded controls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= dec_ctrl;
		rs_s1   <= cmd.rs_value;
		rt_s1   <= cmd.rt_value;
		idx_s1  <= cmd.instr[25:0];
		pc_s1   <= cmd.pc;
	end

	// stage 2: ALU, compare, target adds
	assign simm = {{16{idx_s1[15]}}, idx_s1[15:0]};
	assign pc4  = pc_s1 + 32'd4;
	assign link = pc_s1 + 32'd8;

	always_comb begin
		case (ctrl_s1.src_b)
			SRC_SIMM: opb = simm;
			SRC_ZIMM: opb = {16'd0, idx_s1[15:0]};
			default:  opb = rt_s1;
		endcase
	end

	mde_alu u_alu (
		.op     (ctrl_s1.alu_op),
		.a      (rs_s1),
		.b      (opb),
		.shamt  (idx_s1[10:6]),
		.result (alu_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s2 <= ctrl_s1;
		alu_s2  <= (ctrl_s1.alu_op == ALU_LINK) ? link : alu_out;
		eq_s2   <= (rs_s1 == rt_s1);
		pc4_s2  <= pc4;
		link_s2 <= link;
		btgt_s2 <= pc4 + {simm[29:0], 2'b00};
		jtgt_s2 <= {pc4[31:28], idx_s1, 2'b00};
		rs_s2   <= rs_s1;
		sd_s2   <= ctrl_s1.store_en ? rt_s1 : 32'd0;
	end

	// stage 3: resolve redirect, hold result
	always_comb begin
		redir = 1'b0;
		npc   = pc4_s2;
		case (ctrl_s2.br)
			BR_EQ: begin
				redir = eq_s2;
				npc   = eq_s2 ? btgt_s2 : pc4_s2;
			end
			BR_NE: begin
				redir = !eq_s2;
				npc   = eq_s2 ? pc4_s2 : btgt_s2;
			end
			BR_JUMP: begin
				redir = 1'b1;
				npc   = jtgt_s2;
			end
			BR_REG: begin
				redir = 1'b1;
				npc   = rs_s2;
			end
			default: begin
				redir = 1'b0;
				npc   = pc4_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		res_s3.alu_result        <= alu_s2;
		res_s3.dest_reg          <= ctrl_s2.dest_reg;
		res_s3.reg_write         <= ctrl_s2.reg_write;
		res_s3.write_from_memory <= ctrl_s2.write_from_memory;
		res_s3.mem_read          <= ctrl_s2.mem_read;
		res_s3.mem_write         <= ctrl_s2.mem_write;
		res_s3.store_data        <= sd_s2;
		res_s3.redirect          <= redir;
		res_s3.next_pc           <= npc;
		res_s3.instr_class       <= ctrl_s2.instr_class;
		res_s3.link_value        <= link_s2;
	end

	assign done = valid_s3;
	assign res  = res_s3;

endmodule

`default_nettype wire
